// ===== design/lx_pkg.sv =====
// lx_pkg: shared types, codes and character-class functions for the line lexer.
// Used by lx_step, line_lexer, lx_chk, lx_scoreboard and line_lexer_tb. No dependencies.
package lx_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_ID   = 3'd3,
    MODE_SKIP = 3'd4
  } lex_mode_t;

  localparam logic [1:0] KIND_SYM = 2'd0;
  localparam logic [1:0] KIND_STR = 2'd1;
  localparam logic [1:0] KIND_NUM = 2'd2;
  localparam logic [1:0] KIND_ID  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNCLOSED = 2'd1;
  localparam logic [1:0] ST_UNEXP    = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  typedef struct packed {
    logic       prev_closed;
    logic       token_start;
    logic       char_valid;
    logic [7:0] token_char;
    logic [1:0] token_kind;
    logic       token_closed;
    logic [1:0] status;
  } lx_result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // ~ ( ) [ ] { } < > . , ; = + * - /
  function automatic logic is_symbol(input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      8'h7E, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E,
      8'h2E, 8'h2C, 8'h3B, 8'h3D, 8'h2B, 8'h2A, 8'h2D, 8'h2F: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/lx_step.sv =====
// lx_step: combinational lexer step, one beat in, one result and next mode out.
// Depends on lx_pkg.
module lx_step import lx_pkg::*; (
  input  lex_mode_t  mode,
  input  logic       quote_single,
  input  logic       action,
  input  logic [7:0] ch,
  output lx_result_t res,
  output lex_mode_t  mode_next,
  output logic       quote_next
);

  logic       idle_path;
  logic [7:0] quote_ch;

  assign quote_ch = quote_single ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    res        = '0;
    mode_next  = mode;
    quote_next = quote_single;
    idle_path  = 1'b0;

    if (action == ACT_EOL) begin
      unique case (mode)
        MODE_STR: begin
          res.token_kind = KIND_STR;
          res.status     = ST_UNCLOSED;
        end
        MODE_NUM: begin
          res.prev_closed = 1'b1;
          res.token_kind  = KIND_NUM;
        end
        MODE_ID: begin
          res.prev_closed = 1'b1;
          res.token_kind  = KIND_ID;
        end
        default: ;
      endcase
      mode_next  = MODE_IDLE;
      quote_next = 1'b0;
    end else begin
      unique case (mode)
        MODE_SKIP: res.status = ST_IGNORED;
        MODE_STR: begin
          res.token_kind = KIND_STR;
          if (ch == quote_ch) begin
            res.token_closed = 1'b1;
            mode_next        = MODE_IDLE;
          end else begin
            res.char_valid = 1'b1;
            res.token_char = ch;
          end
        end
        MODE_NUM: begin
          res.token_kind = KIND_NUM;
          if (is_digit(ch) || ch == CH_DOT || ch == CH_UNDER) begin
            res.char_valid = 1'b1;
            res.token_char = ch;
          end else begin
            res.prev_closed = 1'b1;
            idle_path       = 1'b1;
          end
        end
        MODE_ID: begin
          res.token_kind = KIND_ID;
          if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER) begin
            res.char_valid = 1'b1;
            res.token_char = ch;
          end else begin
            res.prev_closed = 1'b1;
            idle_path       = 1'b1;
          end
        end
        default: idle_path = 1'b1;
      endcase

      // Reclassify the byte from idle; a closed token's kind survives
      // unless a new token starts here.
      if (idle_path) begin
        mode_next = MODE_IDLE;
        if (ch == CH_HASH) begin
          mode_next  = MODE_SKIP;
          res.status = ST_IGNORED;
        end else if (is_space(ch)) begin
          res.status = ST_IGNORED;
        end else if (is_symbol(ch)) begin
          res.token_start  = 1'b1;
          res.char_valid   = 1'b1;
          res.token_char   = ch;
          res.token_kind   = KIND_SYM;
          res.token_closed = 1'b1;
        end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
          mode_next       = MODE_STR;
          quote_next      = (ch == CH_SQUOTE);
          res.token_start = 1'b1;
          res.token_kind  = KIND_STR;
        end else if (is_digit(ch)) begin
          mode_next       = MODE_NUM;
          res.token_start = 1'b1;
          res.char_valid  = 1'b1;
          res.token_char  = ch;
          res.token_kind  = KIND_NUM;
        end else if (is_alpha(ch) || ch == CH_UNDER) begin
          mode_next       = MODE_ID;
          res.token_start = 1'b1;
          res.char_valid  = 1'b1;
          res.token_char  = ch;
          res.token_kind  = KIND_ID;
        end else begin
          // NUL, non-ASCII and other stray bytes
          mode_next  = MODE_SKIP;
          res.status = ST_UNEXP;
        end
      end
    end
  end

endmodule

// ===== design/line_lexer.sv =====
// line_lexer: top level of the per-character line tokenizer.
// Depends on lx_pkg and lx_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per character or
//   end-of-line marker (action = 1). Output channel (out_valid/out_ready)
//   returns exactly one result beat per input beat, in order.
//   Path: a beat accepted on the input passes through the input register,
//   one level of classify logic and the result register to the output.
//   Throughput: one beat per cycle sustained while out_ready is high; the
//   limit is the single mode register update that each character needs.
//   Stall: while a result waits with out_ready low the result register
//   holds; one more beat can wait in the input register, after which in_ready
//   drops. Nothing is dropped or repeated.
//   Reset (rst, synchronous): both pipeline registers empty, lexer mode
//   idle, quote flag cleared.
//   The lexer mode advances only when a beat moves from the input register
//   into the result register, so stalls never disturb the token state.
module line_lexer import lx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       prev_closed,
  output logic       token_start,
  output logic       char_valid,
  output logic [7:0] token_char,
  output logic [1:0] token_kind,
  output logic       token_closed,
  output logic [1:0] status
);

  // input register
  logic       in_full;
  logic       act_r;
  logic [7:0] ch_r;

  // lexer state
  lex_mode_t  mode;
  logic       quote_single;

  // result register
  lx_result_t res_r;
  logic       out_full;

  lx_result_t res_next;
  lex_mode_t  mode_next;
  logic       quote_next;
  logic       out_load;
  logic       advance;

  assign out_load = !out_full || out_ready;
  assign advance  = in_full && out_load;
  assign in_ready = !in_full || out_load;

  lx_step u_step (
    .mode         (mode),
    .quote_single (quote_single),
    .action       (act_r),
    .ch           (ch_r),
    .res          (res_next),
    .mode_next    (mode_next),
    .quote_next   (quote_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r <= action;
      ch_r  <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      quote_single <= 1'b0;
    end else if (advance) begin
      mode         <= mode_next;
      quote_single <= quote_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_next;
    end
  end

  assign out_valid    = out_full;
  assign prev_closed  = res_r.prev_closed;
  assign token_start  = res_r.token_start;
  assign char_valid   = res_r.char_valid;
  assign token_char   = res_r.token_char;
  assign token_kind   = res_r.token_kind;
  assign token_closed = res_r.token_closed;
  assign status       = res_r.status;

endmodule

// ===== design/lx_chk.sv =====
// lx_chk: port-level checker for line_lexer, bound to the top level below.
// Depends on lx_pkg.
module lx_chk import lx_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       prev_closed,
  input logic       token_start,
  input logic       char_valid,
  input logic [7:0] token_char,
  input logic [1:0] token_kind,
  input logic       token_closed,
  input logic [1:0] status
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_char) &&
      $stable(token_kind) && $stable(status) && $stable(token_start) &&
      $stable(prev_closed) && $stable(char_valid) && $stable(token_closed))
    else $error("result beat changed while stalled");

  // both registers empty after reset, so input side open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output valid or input blocked right after reset");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> token_char == 8'h00)
    else $error("token_char nonzero without char_valid");

  a_unclosed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNCLOSED |->
      token_kind == KIND_STR && !char_valid && !token_start && !token_closed)
    else $error("bad unclosed-string report");

  a_symbol: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_start && token_closed |->
      token_kind == KIND_SYM && char_valid && status == ST_OK)
    else $error("single-beat token is not a symbol");

endmodule

bind line_lexer lx_chk u_lx_chk (.*);

// ===== sim/lx_chk.sv =====
// lx_scoreboard: checker for line_lexer. Watches both channels, predicts each
// result beat from the accepted input beats and compares them in order.
// Depends on lx_pkg.
module lx_scoreboard import lx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       action,
  input  logic [7:0] ch,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       prev_closed,
  input  logic       token_start,
  input  logic       char_valid,
  input  logic [7:0] token_char,
  input  logic [1:0] token_kind,
  input  logic       token_closed,
  input  logic [1:0] status,
  output int         fail_count,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam string SYMBOL_SET = "~()[]{}<>.,;=+*-/";

  lex_mode_t  lex_state = MODE_IDLE;
  logic       single_quoted = 1'b0;
  lx_result_t expected_tokens[$];
  int         errs = 0;
  int         result_beats = 0;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < SYMBOL_SET.len(); k++)
      if (SYMBOL_SET[k] == c) hit = 1'b1;
    return hit;
  endfunction

  // Advance the lexer state by one beat and return the result it yields.
  function automatic lx_result_t lex_next(input logic act, input logic [7:0] c);
    lx_result_t r;
    lex_mode_t  m;
    logic [7:0] closer;
    r = '0;
    m = lex_state;
    closer = single_quoted ? CH_SQUOTE : CH_DQUOTE;
    if (act == ACT_EOL) begin
      if (m == MODE_STR) begin
        r.token_kind = KIND_STR;
        r.status = ST_UNCLOSED;
      end else if (m == MODE_NUM || m == MODE_ID) begin
        r.prev_closed = 1'b1;
        r.token_kind = (m == MODE_NUM) ? KIND_NUM : KIND_ID;
      end
      lex_state = MODE_IDLE;
      single_quoted = 1'b0;
    end else if (m == MODE_SKIP) begin
      r.status = ST_IGNORED;
    end else if (m == MODE_STR) begin
      r.token_kind = KIND_STR;
      if (c == closer) begin
        r.token_closed = 1'b1;
        lex_state = MODE_IDLE;
      end else begin
        r.char_valid = 1'b1;
        r.token_char = c;
      end
    end else if (m == MODE_NUM && (is_num(c) || c == CH_DOT || c == CH_UNDER)) begin
      r.char_valid = 1'b1;
      r.token_char = c;
      r.token_kind = KIND_NUM;
    end else if (m == MODE_ID && (is_letter(c) || is_num(c) || c == CH_UNDER)) begin
      r.char_valid = 1'b1;
      r.token_char = c;
      r.token_kind = KIND_ID;
    end else begin
      // close any pending number/identifier, then class c from idle
      if (m == MODE_NUM || m == MODE_ID) begin
        r.prev_closed = 1'b1;
        r.token_kind = (m == MODE_NUM) ? KIND_NUM : KIND_ID;
      end
      lex_state = MODE_IDLE;
      if (c == CH_HASH) begin
        lex_state = MODE_SKIP;
        r.status = ST_IGNORED;
      end else if (is_blank(c)) begin
        r.status = ST_IGNORED;
      end else if (is_punct(c)) begin
        r.token_start = 1'b1;
        r.char_valid = 1'b1;
        r.token_char = c;
        r.token_kind = KIND_SYM;
        r.token_closed = 1'b1;
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        lex_state = MODE_STR;
        single_quoted = (c == CH_SQUOTE);
        r.token_start = 1'b1;
        r.token_kind = KIND_STR;
      end else if (is_num(c)) begin
        lex_state = MODE_NUM;
        r.token_start = 1'b1;
        r.char_valid = 1'b1;
        r.token_char = c;
        r.token_kind = KIND_NUM;
      end else if (is_letter(c) || c == CH_UNDER) begin
        lex_state = MODE_ID;
        r.token_start = 1'b1;
        r.char_valid = 1'b1;
        r.token_char = c;
        r.token_kind = KIND_ID;
      end else begin
        // NUL, non-ASCII, control and stray punctuation bytes: skip rest of line
        lex_state = MODE_SKIP;
        r.status = ST_UNEXP;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: result beat %0d: %s", $realtime, result_beats, msg);
    errs++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : monitor
    lx_result_t want;
    if (rst) begin
      lex_state = MODE_IDLE;
      single_quoted = 1'b0;
      expected_tokens.delete();
    end else begin
      if (in_valid === 1'b1 && in_ready === 1'b1)
        expected_tokens = {expected_tokens, lex_next(action, ch)};
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_tokens.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = expected_tokens.pop_front();
          check_field("prev_closed", 8'(prev_closed), 8'(want.prev_closed));
          check_field("token_start", 8'(token_start), 8'(want.token_start));
          check_field("char_valid", 8'(char_valid), 8'(want.char_valid));
          check_field("token_char", token_char, want.token_char);
          check_field("token_kind", 8'(token_kind), 8'(want.token_kind));
          check_field("token_closed", 8'(token_closed), 8'(want.token_closed));
          check_field("status", 8'(status), 8'(want.status));
        end
        result_beats++;
      end
    end
    fail_count <= errs;
    outstanding <= expected_tokens.size();
  end

endmodule

// ===== sim/line_lexer_tb.sv =====
// line_lexer_tb: stimulus and verdict for the line tokenizer.
// Directed lines, then random well-formed lines with noise, under three idle
// mixes. Depends on lx_pkg, line_lexer and the lx_scoreboard checker.
module line_lexer_tb;
  import lx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Quiet-cycle limit: far beyond the longest run of random stalls at 83%.
  localparam int QUIET_LIMIT = 1000;

  localparam string LETTERS = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
  localparam string DIGITS  = "0123456789";
  localparam string SYMBOLS = "~()[]{}<>.,;=+*-/";
  // printable bytes that belong to no class
  localparam string STRAYS  = "!$%&:?@\\^`|";

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       action = ACT_CHAR;
  logic [7:0] ch = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       prev_closed, token_start, char_valid, token_closed;
  logic [7:0] token_char;
  logic [1:0] token_kind, status;

  int fail_count, outstanding;
  int beats_sent = 0;
  int send_idle_pct = 7;
  int recv_idle_pct = 83;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_lexer dut (
    .clk, .rst, .in_valid, .in_ready, .action, .ch,
    .out_valid, .out_ready, .prev_closed, .token_start, .char_valid,
    .token_char, .token_kind, .token_closed, .status
  );

  lx_scoreboard chk (
    .clk, .rst, .in_valid, .in_ready, .action, .ch,
    .out_valid, .out_ready, .prev_closed, .token_start, .char_valid,
    .token_char, .token_kind, .token_closed, .status,
    .fail_count, .outstanding
  );

  // Receiver: independent random stall each cycle.
  always @(posedge clk)
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // Watchdog: ends the run if no beat moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("line_lexer verification failed");
    $finish;
  end

  // One input beat: random idle cycles first, then hold until accepted.
  task automatic send_beat(input logic act, input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    ch <= c;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_beat(ACT_CHAR, c);
  endtask

  // ch carries junk on end of line; the lexer must ignore it
  task automatic send_eol();
    send_beat(ACT_EOL, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k]);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // One random token, mostly well formed. Strings get arbitrary bytes
  // (NUL and high bytes too) and are sometimes left open to end of line.
  task automatic emit_token();
    int len;
    logic [7:0] q, b;
    len = $urandom_range(0, 5);
    case ($urandom_range(0, 9))
      0, 1: begin
        send_char(($urandom_range(0, 4) == 0) ? CH_UNDER : pick(LETTERS));
        repeat (len) send_char(pick({LETTERS, DIGITS, "_"}));
      end
      2, 3: begin
        send_char(pick(DIGITS));
        repeat (len) send_char(pick({DIGITS, "._"}));
      end
      4: begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        send_char(q);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          send_char((b == q) ? ~q : b);
        end
        if ($urandom_range(0, 3) != 0) send_char(q);
      end
      5: send_char(pick(SYMBOLS));
      6: send_char($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
      7: begin
        // unexpected byte, then bytes the lexer skips
        case ($urandom_range(0, 2))
          0: send_char(8'h00);
          1: send_char(8'($urandom_range(128, 255)));
          default: send_char(pick(STRAYS));
        endcase
        repeat (len) send_char(8'($urandom_range(0, 255)));
      end
      8: begin
        send_char(CH_HASH);
        repeat (len) send_char(8'($urandom_range(0, 255)));
      end
      default: send_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic emit_line();
    repeat ($urandom_range(1, 8)) emit_token();
    send_eol();
  endtask

  // Sender holds off until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // identifier with tab close, number with dot/underscore closed by symbol
    send_text("aZ_9\t0._7+");
    // double-quoted string holding NUL, 0xFF and the other quote
    send_char(CH_DQUOTE);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_SQUOTE);
    send_char(CH_DQUOTE);
    // single-quoted string left open at end of line
    send_char(CH_SQUOTE);
    send_eol();
    // comment swallows the rest of the line
    send_text("#x");
    send_eol();
    // leading dot symbol; identifier ended by a non-ASCII byte
    send_text(".q");
    send_char(8'hFF);
    send_char("a");
    send_eol();
    // NUL outside a string is unexpected
    send_char(8'h00);
    send_eol();
    // number pending at end of line, then end of line while idle
    send_char("7");
    send_eol();
    send_eol();

    // sender idles rarely, receiver often
    while (beats_sent < 400) emit_line();
    drain();

    send_idle_pct = 83;
    recv_idle_pct <= 7;
    while (beats_sent < 780) emit_line();
    drain();

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    while (beats_sent < 1150) emit_line();
    drain();

    // wait past the two-register pipeline for stray beats
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("line_lexer verification clean");
    else
      $display("line_lexer verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/lx_pkg.sv
design/lx_step.sv
design/line_lexer.sv
design/lx_chk.sv
sim/lx_chk.sv
sim/line_lexer_tb.sv
